FILE: rtl/fdc_pkg.sv
// Shared widths, the controller state type and the result record for the dominance counter.
`timescale 1ns / 1ps

package fdc_pkg;

    localparam int START_W = 17;
    localparam int END_W = 17;
    localparam int TAG_W = 20;
    localparam int OUT_W = 20;
    // Set-generation mark kept beside each tree entry.
    localparam int EPOCH_BITS = 8;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_QUERY,
        S_UPDATE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [OUT_W-1:0] count;
        logic [TAG_W-1:0] tag;
    } t_result;

endpackage

FILE: rtl/fdc_if.sv
// Request and result channel interfaces of the dominance counter.
`timescale 1ns / 1ps

interface fdc_req_if;
    import fdc_pkg::*;

    logic               valid;
    logic               ready;
    logic [START_W-1:0] start_point;
    logic [END_W-1:0]   end_point;
    logic [TAG_W-1:0]   item_tag;
    logic               first_of_set;

    modport source (output valid, output start_point, output end_point, output item_tag,
                    output first_of_set, input ready);
    modport sink (input valid, input start_point, input end_point, input item_tag,
                  input first_of_set, output ready);
endinterface

interface fdc_rsp_if;
    import fdc_pkg::*;

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] stronger_count;
    logic [TAG_W-1:0] result_tag;

    modport source (output valid, output stronger_count, output result_tag, input ready);
    modport sink (input valid, input stronger_count, input result_tag, output ready);
endinterface

FILE: rtl/fdc_ram.sv
// Single-port-write, single-port-read tree memory with a registered read.
`timescale 1ns / 1ps

module fdc_ram #(
    parameter int DEPTH  = 131072,
    parameter int ADDR_W = 17,
    parameter int DATA_W = 28
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/fdc_ctrl.sv
// Sequencer that walks the tree for the prefix count and the increment of each request.
`timescale 1ns / 1ps

module fdc_ctrl #(
    parameter int TREE_SIZE  = 131072,
    parameter int COUNT_BITS = 20,
    parameter int IDX_W      = 18,
    parameter int ADDR_W     = 17,
    parameter int DATA_W     = 28
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    fdc_req_if.sink           i_req,
    input  logic              i_res_space,
    output logic              o_res_load,
    output fdc_pkg::t_result  o_res,
    output logic              o_we,
    output logic [ADDR_W-1:0] o_waddr,
    output logic [DATA_W-1:0] o_wdata,
    output logic              o_re,
    output logic [ADDR_W-1:0] o_raddr,
    input  logic [DATA_W-1:0] i_rdata
);
    import fdc_pkg::*;

    localparam int CW = (IDX_W > START_W + 1) ? IDX_W : START_W + 1;
    localparam int SUM_W = ((COUNT_BITS > OUT_W) ? COUNT_BITS : OUT_W) + 1;
    localparam logic [OUT_W-1:0] LIM = (COUNT_BITS < OUT_W) ?
        OUT_W'((64'd1 << COUNT_BITS) - 64'd1) : {OUT_W{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [IDX_W:0] TREE_LAST = (IDX_W + 1)'(TREE_SIZE);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(TREE_SIZE - 1);

    t_state               r_state, n_state;
    logic [ADDR_W-1:0]    r_clr_addr, n_clr_addr;
    logic [EPOCH_BITS-1:0] r_epoch, n_epoch;
    logic                 r_pend, n_pend;
    logic [START_W-1:0]   r_start, n_start;
    logic [END_W-1:0]     r_end, n_end;
    logic [TAG_W-1:0]     r_tag, n_tag;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [IDX_W:0]       r_walk, n_walk;
    logic                 r_rd_pend, n_rd_pend;
    logic [ADDR_W-1:0]    r_waddr, n_waddr;
    logic [OUT_W-1:0]     r_acc, n_acc;
    logic [START_W-1:0]   r_prev_start, n_prev_start;
    logic [END_W-1:0]     r_prev_end, n_prev_end;
    logic [OUT_W-1:0]     r_prev_count, n_prev_count;
    logic                 r_have_prev, n_have_prev;

    logic [COUNT_BITS-1:0] rd_cnt;
    logic [COUNT_BITS-1:0] inc_cnt;
    logic [SUM_W-1:0]      sum;
    logic [OUT_W-1:0]      sat_sum;
    logic [CW-1:0]         ext_idx;
    logic [IDX_W-1:0]      in_idx;
    logic                  dup;

    // An entry written under an older set mark reads as zero.
    assign rd_cnt = (i_rdata[DATA_W-1 -: EPOCH_BITS] == r_epoch) ?
                    i_rdata[COUNT_BITS-1:0] : '0;
    assign inc_cnt = (rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + 1'b1;
    assign sum = SUM_W'(r_acc) + SUM_W'(rd_cnt);
    assign sat_sum = (sum > SUM_W'(LIM)) ? LIM : OUT_W'(sum);

    assign ext_idx = CW'(i_req.start_point) + CW'(1);
    assign in_idx = (ext_idx > CW'(TREE_SIZE)) ? IDX_W'(TREE_SIZE) : IDX_W'(ext_idx);
    assign dup = r_have_prev && !i_req.first_of_set &&
                 (i_req.start_point == r_prev_start) && (i_req.end_point == r_prev_end);

    assign o_res = '{count: r_acc, tag: r_tag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_epoch      <= '0;
            r_pend       <= 1'b0;
            r_rd_pend    <= 1'b0;
            r_have_prev  <= 1'b0;
            r_prev_start <= '0;
            r_prev_end   <= '0;
            r_prev_count <= '0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_epoch      <= n_epoch;
            r_pend       <= n_pend;
            r_rd_pend    <= n_rd_pend;
            r_have_prev  <= n_have_prev;
            r_prev_start <= n_prev_start;
            r_prev_end   <= n_prev_end;
            r_prev_count <= n_prev_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start <= n_start;
        r_end   <= n_end;
        r_tag   <= n_tag;
        r_idx   <= n_idx;
        r_walk  <= n_walk;
        r_waddr <= n_waddr;
        r_acc   <= n_acc;
    end

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_epoch      = r_epoch;
        n_pend       = r_pend;
        n_start      = r_start;
        n_end        = r_end;
        n_tag        = r_tag;
        n_idx        = r_idx;
        n_walk       = r_walk;
        n_rd_pend    = r_rd_pend;
        n_waddr      = r_waddr;
        n_acc        = r_acc;
        n_prev_start = r_prev_start;
        n_prev_end   = r_prev_end;
        n_prev_count = r_prev_count;
        n_have_prev  = r_have_prev;
        i_req.ready  = 1'b0;
        o_res_load   = 1'b0;
        o_we         = 1'b0;
        o_waddr      = r_clr_addr;
        o_wdata      = '0;
        o_re         = 1'b0;
        o_raddr      = ADDR_W'(r_walk - 1'b1);

        unique case (r_state)
            S_CLEAR: begin
                // Sweep stamps every entry with mark zero and a zero count.
                o_we = 1'b1;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_LAST) begin
                    n_clr_addr = '0;
                    n_pend = 1'b0;
                    n_state = r_pend ? S_QUERY : S_IDLE;
                end
            end
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_start = i_req.start_point;
                    n_end = i_req.end_point;
                    n_tag = i_req.item_tag;
                    n_idx = in_idx;
                    n_walk = {1'b0, in_idx};
                    n_rd_pend = 1'b0;
                    n_acc = '0;
                    if (i_req.first_of_set) begin
                        n_have_prev = 1'b0;
                        n_prev_start = '0;
                        n_prev_end = '0;
                        n_prev_count = '0;
                        n_epoch = r_epoch + 1'b1;
                        // When the mark wraps, old entries must really be wiped.
                        if (r_epoch == {EPOCH_BITS{1'b1}}) begin
                            n_pend = 1'b1;
                            n_state = S_CLEAR;
                        end else begin
                            n_state = S_QUERY;
                        end
                    end else if (dup) begin
                        n_acc = r_prev_count;
                        n_state = S_UPDATE;
                    end else begin
                        n_state = S_QUERY;
                    end
                end
            end
            S_QUERY: begin
                if (r_rd_pend) begin
                    n_acc = sat_sum;
                end
                if (r_walk != '0) begin
                    o_re = 1'b1;
                    n_walk = r_walk & (r_walk - 1'b1);
                    n_rd_pend = 1'b1;
                end else begin
                    n_rd_pend = 1'b0;
                    if (!r_rd_pend) begin
                        n_walk = {1'b0, r_idx};
                        n_state = S_UPDATE;
                    end
                end
            end
            S_UPDATE: begin
                // The walk climbs strictly upward, so a write never meets its own read.
                if (r_rd_pend) begin
                    o_we = 1'b1;
                    o_waddr = r_waddr;
                    o_wdata = {r_epoch, inc_cnt};
                end
                if (r_walk <= TREE_LAST) begin
                    o_re = 1'b1;
                    n_waddr = ADDR_W'(r_walk - 1'b1);
                    n_walk = r_walk + (r_walk & (~r_walk + 1'b1));
                    n_rd_pend = 1'b1;
                end else begin
                    n_rd_pend = 1'b0;
                    if (!r_rd_pend) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (i_res_space) begin
                    o_res_load = 1'b1;
                    n_prev_start = r_start;
                    n_prev_end = r_end;
                    n_prev_count = r_acc;
                    n_have_prev = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/fdc_outbuf.sv
// Output register that holds one result until the downstream side takes it.
`timescale 1ns / 1ps

module fdc_outbuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  fdc_pkg::t_result i_res,
    output logic             o_space,
    fdc_rsp_if.source        o_rsp
);
    import fdc_pkg::*;

    logic             r_valid;
    logic [OUT_W-1:0] r_count;
    logic [TAG_W-1:0] r_tag;

    assign o_space = !r_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_count <= i_res.count;
            r_tag   <= i_res.tag;
        end
    end

    assign o_rsp.valid = r_valid;
    assign o_rsp.stronger_count = r_count;
    assign o_rsp.result_tag = r_tag;

endmodule

FILE: rtl/fenwick_dominance_counter.sv
// Top level of the interval dominance counter built on a binary indexed tree in memory.
//
//   Channel  Dir  Payload                                          Handshake
//   i_req    in   start_point, end_point, item_tag, first_of_set   valid / ready
//   o_rsp    out  stronger_count, result_tag                       valid / ready
//
// One request at a time: a prefix walk over tree entries from start+1 downward, then the
// increment walk over tree entries from start+1 upward, then the result is loaded; the single
// memory read port paces both walks. A repeat of the previous interval skips the prefix walk.
// After reset, and on every 256th first-of-set request, a clearing pass sweeps the memory;
// no request is taken meanwhile.
// A finished result waits in the output register while the next request is taken.
`timescale 1ns / 1ps

module fenwick_dominance_counter #(
    parameter int TREE_SIZE  = 131072,
    parameter int COUNT_BITS = 20
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fdc_req_if.sink   i_req,
    fdc_rsp_if.source o_rsp
);
    import fdc_pkg::*;

    localparam int IDX_W = $clog2(TREE_SIZE + 1);
    localparam int ADDR_W = $clog2(TREE_SIZE);
    localparam int DATA_W = EPOCH_BITS + COUNT_BITS;

    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [DATA_W-1:0] w_wdata;
    logic              w_re;
    logic [ADDR_W-1:0] w_raddr;
    logic [DATA_W-1:0] w_rdata;
    logic              w_space;
    logic              w_load;
    t_result           w_res;

    fdc_ctrl #(
        .TREE_SIZE  (TREE_SIZE),
        .COUNT_BITS (COUNT_BITS),
        .IDX_W      (IDX_W),
        .ADDR_W     (ADDR_W),
        .DATA_W     (DATA_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_res_space (w_space),
        .o_res_load  (w_load),
        .o_res       (w_res),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_re        (w_re),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata)
    );

    fdc_ram #(
        .DEPTH  (TREE_SIZE),
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    fdc_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_res   (w_res),
        .o_space (w_space),
        .o_rsp   (o_rsp)
    );

    // The memory is swept after reset before any request is taken.
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_req.ready)
        else $error("request taken before the clearing pass");

    // A read and a write in the same cycle never target the same entry.
    a_no_same_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && w_re) |-> (w_waddr != w_raddr))
        else $error("read and write collide on one tree entry");

    // Only one request is in work at a time.
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("second request taken while one is in work");

    // A result is loaded only when the output register can hold it.
    a_load_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |-> !w_load)
        else $error("result overwrote an untaken result");

endmodule

FILE: sim/fdc_score_pkg.sv
// Scoreboard class that predicts and checks the dominance counter results.
`timescale 1ns / 1ps

package fdc_score_pkg;
    import fdc_pkg::*;

    localparam int     LEAVES    = 131072;
    localparam int     CNT_BITS  = 20;
    localparam longint ENTRY_MAX = (longint'(1) << CNT_BITS) - 1;
    localparam longint OUT_MAX   = (longint'(1) << OUT_W) - 1;

    class count_scoreboard;
        // Sparse copy of the tree: an absent entry reads as zero.
        longint             tree[int];
        logic [START_W-1:0] last_start;
        logic [END_W-1:0]   last_end;
        logic [OUT_W-1:0]   last_count;
        bit                 have_last;
        t_result            expected_q[$];
        int                 errors;

        function new();
            clear_set();
            errors = 0;
        endfunction

        function void clear_set();
            tree.delete();
            last_start = '0;
            last_end   = '0;
            last_count = '0;
            have_last  = 1'b0;
        endfunction

        function longint prefix_sum(int idx);
            longint acc;
            longint lim;
            acc = 0;
            lim = (ENTRY_MAX < OUT_MAX) ? ENTRY_MAX : OUT_MAX;
            while (idx != 0) begin
                if (tree.exists(idx)) acc += tree[idx];
                if (acc > lim) acc = lim;
                idx -= idx & (-idx);
            end
            return acc;
        endfunction

        function void bump(int idx);
            while (idx != 0 && idx <= LEAVES) begin
                if (!tree.exists(idx)) tree[idx] = 0;
                if (tree[idx] < ENTRY_MAX) tree[idx] += 1;
                idx += idx & (-idx);
            end
        endfunction

        function void note_request(logic [START_W-1:0] s, logic [END_W-1:0] e,
                                   logic [TAG_W-1:0] tag, logic fos);
            int      idx;
            longint  cnt;
            t_result r;
            if (fos) clear_set();
            idx = int'(s) + 1;
            if (idx > LEAVES) idx = LEAVES;
            // An exact copy of the previous interval takes its count without a tree read.
            if (have_last && s == last_start && e == last_end) cnt = last_count;
            else cnt = prefix_sum(idx);
            bump(idx);
            last_start = s;
            last_end   = e;
            last_count = cnt[OUT_W-1:0];
            have_last  = 1'b1;
            r.count = cnt[OUT_W-1:0];
            r.tag   = tag;
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [OUT_W-1:0] cnt, logic [TAG_W-1:0] tag);
            t_result exp_r;
            if (expected_q.size() == 0) begin
                $error("unexpected result: stronger_count %0d result_tag 0x%0h", cnt, tag);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (cnt !== exp_r.count) begin
                $error("stronger_count: expected %0d, actual %0d", exp_r.count, cnt);
                errors++;
            end
            if (tag !== exp_r.tag) begin
                $error("result_tag: expected 0x%0h, actual 0x%0h", exp_r.tag, tag);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

endpackage

FILE: sim/tb_top.sv
// Top-level testbench of the dominance counter: stimulus, handshake driving and checking.
`timescale 1ns / 1ps

module tb_top;
    import fdc_pkg::*;
    import fdc_score_pkg::*;

    localparam int STALL_LIMIT   = 500000;
    localparam int PHASE_ITEMS   = 150;
    localparam int DRAIN_CYCLES  = 100;
    localparam logic [START_W-1:0] S_MAX = '1;
    localparam logic [END_W-1:0]   E_MAX = '1;
    localparam logic [TAG_W-1:0]   T_MAX = '1;

    logic i_clk;
    logic i_rst_n;

    fdc_req_if req_if ();
    fdc_rsp_if rsp_if ();

    fenwick_dominance_counter DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    count_scoreboard sb = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;
    int quiet_cycles   = 0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Receiver side, request monitor and watchdog, all sampled at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready)
                sb.check_result(rsp_if.stronger_count, rsp_if.result_tag);
            if (req_if.valid && req_if.ready)
                sb.note_request(req_if.start_point, req_if.end_point, req_if.item_tag,
                                req_if.first_of_set);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb_top NOT OK");
                $finish;
            end
        end
        rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic send_interval(input logic [START_W-1:0] s, input logic [END_W-1:0] e,
                                 input logic [TAG_W-1:0] tag, input logic fos);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.start_point  <= s;
        req_if.end_point    <= e;
        req_if.item_tag     <= tag;
        req_if.first_of_set <= fos;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        items_sent++;
    endtask

    // One set in the expected order: ends descending, starts ascending within an end.
    task automatic send_sorted_set();
        int n;
        int lim;
        int step;
        int r;
        int s;
        int e;
        r = $urandom_range(0, 99);
        if (r < 60) lim = 31;
        else if (r < 85) lim = 1023;
        else lim = int'(S_MAX);
        step = (lim < 32) ? 3 : lim / 8;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24);
        e = lim - $urandom_range(0, lim / 4);
        s = $urandom_range(0, lim);
        for (int i = 0; i < n; i++) begin
            if (i > 0) begin
                r = $urandom_range(0, 99);
                if (r < 20) begin
                    // Exact repeat of the previous interval.
                end else if (r < 55 || e == 0) begin
                    s = s + $urandom_range(1, step);
                    if (s > lim) s = lim;
                end else begin
                    e = e - $urandom_range(1, step);
                    if (e < 0) e = 0;
                    s = $urandom_range(0, lim);
                end
            end
            send_interval(s[START_W-1:0], e[END_W-1:0],
                          TAG_W'($urandom_range(0, int'(T_MAX))), (i == 0));
        end
    endtask

    task automatic send_noise();
        int n;
        int lim;
        n = $urandom_range(1, 6);
        lim = ($urandom_range(0, 1) == 0) ? 15 : int'(S_MAX);
        for (int i = 0; i < n; i++)
            send_interval(START_W'($urandom_range(0, lim)), END_W'($urandom_range(0, lim)),
                          TAG_W'($urandom_range(0, int'(T_MAX))),
                          ($urandom_range(0, 9) == 0));
    endtask

    initial begin
        int phase_end;
        i_rst_n             <= 1'b0;
        req_if.valid        <= 1'b0;
        req_if.start_point  <= '0;
        req_if.end_point    <= '0;
        req_if.item_tag     <= '0;
        req_if.first_of_set <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: field extremes, repeats, set boundaries and unsorted order.
        send_interval('0, '0, '0, 1'b0);
        send_interval('0, '0, T_MAX, 1'b0);
        send_interval('0, E_MAX, 20'h00001, 1'b0);
        send_interval(S_MAX, E_MAX, 20'h00002, 1'b0);
        send_interval(S_MAX, E_MAX, 20'h00003, 1'b0);
        send_interval(S_MAX, '0, 20'h00004, 1'b0);
        // A copy of the previous interval that opens a new set is counted afresh.
        send_interval(S_MAX, '0, 20'h00005, 1'b1);
        send_interval(17'd5, 17'd100, 20'h00006, 1'b1);
        send_interval(17'd5, 17'd100, 20'h00007, 1'b0);
        send_interval(17'd3, 17'd100, 20'h00008, 1'b0);
        send_interval(17'd5, 17'd100, 20'h00009, 1'b0);
        send_interval(17'd6, 17'd99, 20'h0000A, 1'b0);
        send_interval(17'h15555, 17'h0AAAA, 20'h55555, 1'b0);
        send_interval(17'h0AAAA, 17'h15555, 20'hAAAAA, 1'b0);
        send_interval(17'd65535, 17'd65536, 20'h7FFFF, 1'b0);
        send_interval(17'd65536, 17'd65535, 20'h80000, 1'b0);
        send_interval(S_MAX, E_MAX, T_MAX, 1'b1);
        send_interval(S_MAX, E_MAX, '0, 1'b0);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 57;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 57;
                end
                default: begin
                    send_idle_pct  = 20;
                    recv_stall_pct = 20;
                end
            endcase
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 99) < 15) send_noise();
                else send_sorted_set();
            end
        end

        req_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
